// ===== hdl/i2cmbs_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none

package i2cmbs_pkg;

  // Bits in one byte on the bus, and the SCL low/high phases they take.
  localparam int unsigned BitsPerByte   = 8;
  localparam int unsigned PhasesPerByte = 2 * BitsPerByte;

  // Command codes; the idle code doubles as the tick-only action.
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_WAIT  = 3'd6
  } op_e;

  // Sequencer state carried from one tick to the next.
  typedef struct packed {
    op_e        op;
    logic [4:0] phase;
    logic [3:0] bit_cnt;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic       ack;
    logic       nack;
    logic [7:0] rx_hold;
  } seq_state_t;

  // Per-tick status that goes with each result word.
  typedef struct packed {
    logic busy;
    logic done;
  } seq_status_t;

endpackage

`default_nettype wire

// ===== hdl/i2c_master_bit_sequencer_core.sv =====
// An accepted word moves on from the input register when the result register is
// free or drains. Throughput: one word per cycle while out_stall_i is low; each
// word runs one bus phase in a single pass of next-state logic between registers.
// Reset: the bus lines are released high, the sequencer is idle, the received
// byte and the ack flags are cleared, and both pipeline stages are empty.
`default_nettype none

module i2c_master_bit_sequencer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [7:0] tx_byte_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic       ack_seen_o,
  output logic       nack_stopped_o
);
  import i2cmbs_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [2:0] action_q;
  logic [7:0] tx_byte_q;
  logic       send_ack_q;
  logic       sda_in_q;

  // Sequencer state and result register.
  seq_state_t  state_q, state_d;
  seq_status_t status_d;
  logic        out_valid_q;
  logic        scl_q, sda_q, busy_q, done_q, ack_q, nack_q;
  logic [7:0]  rx_q;

  logic in_accept;
  logic advance;

  // The input word moves on whenever the result register is free or drains.
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q   <= action_i;
      tx_byte_q  <= tx_byte_i;
      send_ack_q <= send_ack_i;
      sda_in_q   <= sda_in_i;
    end
  end

  i2cmbs_step u_step (
    .state_i    (state_q),
    .action_i   (action_q),
    .tx_byte_i  (tx_byte_q),
    .send_ack_i (send_ack_q),
    .sda_in_i   (sda_in_q),
    .state_o    (state_d),
    .status_o   (status_d)
  );

  // Sequencer state moves one phase per processed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.op      <= OP_IDLE;
      state_q.phase   <= '0;
      state_q.bit_cnt <= '0;
      state_q.shift   <= '0;
      state_q.scl     <= 1'b1;
      state_q.sda     <= 1'b1;
      state_q.ack     <= 1'b0;
      state_q.nack    <= 1'b0;
      state_q.rx_hold <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      scl_q  <= state_d.scl;
      sda_q  <= state_d.sda;
      busy_q <= status_d.busy;
      done_q <= status_d.done;
      rx_q   <= state_d.rx_hold;
      ack_q  <= state_d.ack;
      nack_q <= state_d.nack;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_level_o    = scl_q;
  assign sda_level_o    = sda_q;
  assign busy_res_o     = busy_q;
  assign done_res_o     = done_q;
  assign rx_byte_o      = rx_q;
  assign ack_seen_o     = ack_q;
  assign nack_stopped_o = nack_q;

  // A result word never claims to be both still running and finished.
  a_busy_done_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(busy_res_o && done_res_o))
    else $error("busy and done both set in one result word");

  // The phase counter is parked at zero whenever the sequencer is idle.
  a_idle_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.op == OP_IDLE) |-> (state_q.phase == 5'd0))
    else $error("idle sequencer with nonzero phase");

  // An empty input register never pushes back.
  a_no_false_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // Every processed word shows up in the result register.
  a_advance_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed word lost before the result register");

endmodule

`default_nettype wire

// ===== hdl/i2cmbs_step.sv =====
// Next-state logic for one bus-phase tick of the I2C bus sequencer.
`default_nettype none

module i2cmbs_step (
  input  i2cmbs_pkg::seq_state_t  state_i,
  input  logic [2:0]              action_i,
  input  logic [7:0]              tx_byte_i,
  input  logic                    send_ack_i,
  input  logic                    sda_in_i,
  output i2cmbs_pkg::seq_state_t  state_o,
  output i2cmbs_pkg::seq_status_t status_o
);
  import i2cmbs_pkg::*;

  seq_state_t s;
  logic       fin;
  logic       active;

  always_comb begin
    s      = state_i;
    fin    = 1'b0;
    active = 1'b0;

    // An idle sequencer takes a new command; anything else is ignored.
    if (s.op == OP_IDLE) begin
      if (action_i >= 3'(OP_START) && action_i <= 3'(OP_WAIT)) begin
        s.op      = op_e'(action_i);
        s.phase   = '0;
        s.bit_cnt = '0;
        if (action_i == 3'(OP_WRITE)) begin
          s.shift = tx_byte_i;
        end
      end
    end

    // Run one phase of the current command.
    if (s.op != OP_IDLE) begin
      active = 1'b1;
      case (s.op)
        OP_START: begin
          if (s.phase == 5'd0) s.sda = 1'b1;
          else if (s.phase == 5'd1) s.scl = 1'b1;
          else if (s.phase == 5'd2) s.sda = 1'b0;
          else begin
            s.scl = 1'b0;
            fin   = 1'b1;
          end
        end
        OP_STOP: begin
          if (s.phase == 5'd0) s.sda = 1'b0;
          else if (s.phase == 5'd1) s.scl = 1'b1;
          else begin
            s.sda = 1'b1;
            fin   = 1'b1;
          end
        end
        OP_WRITE: begin
          if (s.phase < 5'(PhasesPerByte)) begin
            if (!s.phase[0]) begin
              // SCL is left alone before the first bit.
              if (s.bit_cnt != 4'd0) s.scl = 1'b0;
              s.sda = s.shift[7];
            end else begin
              s.scl     = 1'b1;
              s.shift   = {s.shift[6:0], 1'b0};
              s.bit_cnt = s.bit_cnt + 4'd1;
            end
          end else begin
            s.scl = 1'b0;
            fin   = 1'b1;
          end
        end
        OP_READ: begin
          if (s.phase == 5'd0) begin
            s.sda = 1'b1;
          end else if (s.phase[0]) begin
            // SCL high: sample the data line.
            s.scl   = 1'b1;
            s.shift = {s.shift[6:0], sda_in_i};
          end else begin
            s.scl     = 1'b0;
            s.bit_cnt = s.bit_cnt + 4'd1;
            if (s.phase >= 5'(PhasesPerByte)) begin
              s.rx_hold = s.shift;
              fin       = 1'b1;
            end
          end
        end
        OP_ACK: begin
          if (s.phase == 5'd0) s.sda = ~send_ack_i;
          else if (s.phase == 5'd1) s.scl = 1'b1;
          else begin
            s.scl = 1'b0;
            s.sda = 1'b1;
            fin   = 1'b1;
          end
        end
        OP_WAIT: begin
          // A NACK keeps going through a stop of its own.
          if (s.phase == 5'd0) begin
            s.sda = 1'b1;
          end else if (s.phase == 5'd1) begin
            s.scl  = 1'b1;
            s.ack  = ~sda_in_i;
            s.nack = sda_in_i;
          end else if (s.phase == 5'd2) begin
            s.scl = 1'b0;
            if (s.ack) fin = 1'b1;
          end else if (s.phase == 5'd3) begin
            s.sda = 1'b0;
          end else if (s.phase == 5'd4) begin
            s.scl = 1'b1;
          end else begin
            s.sda = 1'b1;
            fin   = 1'b1;
          end
        end
        default: begin
          s.op = OP_IDLE;
        end
      endcase

      // Advance the phase counter or return to idle.
      if (fin) begin
        s.op    = OP_IDLE;
        s.phase = '0;
      end else begin
        s.phase = s.phase + 5'd1;
      end
    end
  end

  assign state_o       = s;
  assign status_o.busy = active & ~fin;
  assign status_o.done = fin;

endmodule

`default_nettype wire

// ===== tb/i2c_master_bit_sequencer_core_test.sv =====
// Self-checking testbench for the I2C master bit sequencer core.
`default_nettype none

module i2c_master_bit_sequencer_core_test;
  import i2cmbs_pkg::*;

  // Action code outside the command set; it must act like a plain tick.
  localparam logic [2:0] ActUnused  = 3'd7;
  localparam int unsigned LiveWords = 1500;
  localparam int unsigned StuckLimit = 1000;
  localparam int unsigned HoldCycles = 150;

  // Line levels and status that one word produces.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack;
    logic       nack;
  } line_result_t;

  // Sequencer state as the testbench tracks it.
  typedef struct packed {
    op_e        op;
    logic [4:0] phase;
    logic [3:0] bits;
    logic [7:0] shreg;
    logic       scl;
    logic       sda;
    logic       ack;
    logic       nack;
    logic [7:0] rx;
  } bus_state_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] action_i = OP_IDLE;
  logic [7:0] tx_byte_i = 8'h00;
  logic       send_ack_i = 1'b0;
  logic       sda_in_i = 1'b1;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       scl_level_o;
  logic       sda_level_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] rx_byte_o;
  logic       ack_seen_o;
  logic       nack_stopped_o;

  bus_state_t   bus;
  line_result_t expected_lines[$];
  int unsigned  words_sent = 0;
  int unsigned  live_words = 0;
  int unsigned  lines_checked = 0;
  int unsigned  mismatches = 0;
  int unsigned  stuck_cycles = 0;
  bit           gaps_on = 1'b0;
  bit           stalls_on = 1'b0;
  int unsigned  hold_seq_req = 0;
  int unsigned  hold_seq_seen = 0;
  int unsigned  hold_left = 0;
  int unsigned  burst_left = 0;

  i2c_master_bit_sequencer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .tx_byte_i      (tx_byte_i),
    .send_ack_i     (send_ack_i),
    .sda_in_i       (sda_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scl_level_o    (scl_level_o),
    .sda_level_o    (sda_level_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .rx_byte_o      (rx_byte_o),
    .ack_seen_o     (ack_seen_o),
    .nack_stopped_o (nack_stopped_o)
  );

  always #4 clk_i = ~clk_i;

  // Runs one bus phase on the tracked state and returns the lines it should drive.
  function automatic line_result_t advance_bus(input logic [2:0] act, input logic [7:0] tx,
                                               input logic ack_bit, input logic sda_s);
    line_result_t res;
    logic         fin;
    logic         active;
    logic [4:0]   ph;
    fin = 1'b0;
    active = 1'b0;
    // A command is taken only while idle.
    if (bus.op == OP_IDLE && act >= OP_START && act <= OP_WAIT) begin
      bus.op = op_e'(act);
      bus.phase = '0;
      bus.bits = '0;
      if (act == OP_WRITE) bus.shreg = tx;
    end
    if (bus.op != OP_IDLE) begin
      active = 1'b1;
      ph = bus.phase;
      case (bus.op)
        OP_START: begin
          if (ph == 0) bus.sda = 1'b1;
          else if (ph == 1) bus.scl = 1'b1;
          else if (ph == 2) bus.sda = 1'b0;
          else begin
            bus.scl = 1'b0;
            fin = 1'b1;
          end
        end
        OP_STOP: begin
          if (ph == 0) bus.sda = 1'b0;
          else if (ph == 1) bus.scl = 1'b1;
          else begin
            bus.sda = 1'b1;
            fin = 1'b1;
          end
        end
        OP_WRITE: begin
          // Even phases put the next bit on SDA, odd phases raise SCL.
          if (ph < PhasesPerByte) begin
            if (!ph[0]) begin
              if (bus.bits != 0) bus.scl = 1'b0;
              bus.sda = bus.shreg[7];
            end else begin
              bus.scl = 1'b1;
              bus.shreg = {bus.shreg[6:0], 1'b0};
              bus.bits = bus.bits + 4'd1;
            end
          end else begin
            bus.scl = 1'b0;
            fin = 1'b1;
          end
        end
        OP_READ: begin
          // SDA is released first; odd phases sample on SCL high.
          if (ph == 0) bus.sda = 1'b1;
          else if (ph[0]) begin
            bus.scl = 1'b1;
            bus.shreg = {bus.shreg[6:0], sda_s};
          end else begin
            bus.scl = 1'b0;
            bus.bits = bus.bits + 4'd1;
            if (ph >= PhasesPerByte) begin
              bus.rx = bus.shreg;
              fin = 1'b1;
            end
          end
        end
        OP_ACK: begin
          if (ph == 0) bus.sda = ~ack_bit;
          else if (ph == 1) bus.scl = 1'b1;
          else begin
            bus.scl = 1'b0;
            bus.sda = 1'b1;
            fin = 1'b1;
          end
        end
        default: begin
          // Wait for ACK; a NACK runs on into a stop sequence.
          if (ph == 0) bus.sda = 1'b1;
          else if (ph == 1) begin
            bus.scl = 1'b1;
            bus.ack = ~sda_s;
            bus.nack = sda_s;
          end else if (ph == 2) begin
            bus.scl = 1'b0;
            if (bus.ack) fin = 1'b1;
          end else if (ph == 3) bus.sda = 1'b0;
          else if (ph == 4) bus.scl = 1'b1;
          else begin
            bus.sda = 1'b1;
            fin = 1'b1;
          end
        end
      endcase
      if (fin) begin
        bus.op = OP_IDLE;
        bus.phase = '0;
      end else begin
        bus.phase = bus.phase + 5'd1;
      end
    end
    res.scl = bus.scl;
    res.sda = bus.sda;
    res.busy = active && !fin;
    res.done = fin;
    res.rx = bus.rx;
    res.ack = bus.ack;
    res.nack = bus.nack;
    return res;
  endfunction

  // SDA level a slave would present in the phase about to run.
  function automatic logic slave_sda(input logic [7:0] pattern, input logic slave_ack);
    int unsigned idx;
    if (bus.op == OP_READ && bus.phase[0]) begin
      idx = (int'(bus.phase) - 1) / 2;
      return pattern[7 - idx];
    end
    if (bus.op == OP_WAIT && bus.phase == 1) return ~slave_ack;
    return 1'($urandom_range(1));
  endfunction

  // Offers one word and records its expected lines once it is taken.
  task automatic send_word(input logic [2:0] act, input logic [7:0] tx, input logic ack_bit,
                           input logic sda_s);
    line_result_t res;
    int unsigned  roll;
    int unsigned  gap;
    in_valid_i <= 1'b1;
    action_i <= act;
    tx_byte_i <= tx;
    send_ack_i <= ack_bit;
    sda_in_i <= sda_s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = advance_bus(act, tx, ack_bit, sda_s);
    expected_lines.push_back(res);
    words_sent++;
    if (res.busy || res.done) live_words++;
    gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(99);
      if (roll >= 95) gap = $urandom_range(10, 30);
      else if (roll >= 65) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Issues a command from idle and ticks it to its end; fillers carry stray commands.
  // The data byte is the write value or the pattern a slave returns on a read.
  task automatic run_command(input op_e cmd, input logic [7:0] data, input logic flag);
    send_word(cmd, data, flag, slave_sda(data, flag));
    while (bus.op != OP_IDLE)
      send_word(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                slave_sda(data, flag));
  endtask

  // Drops valid and waits for every outstanding word to come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_lines.size() != 0) @(posedge clk_i);
  endtask

  // Idle ticks, including the unused action code, must hold the lines.
  task automatic test_idle_ticks();
    send_word(OP_IDLE, 8'hFF, 1'b1, 1'b0);
    send_word(ActUnused, 8'h00, 1'b0, 1'b1);
    send_word(OP_IDLE, 8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  // Every command at least once, with byte and ack extremes and both wait outcomes.
  task automatic test_each_command();
    run_command(OP_START, 8'h00, 1'b0);
    run_command(OP_WRITE, 8'h00, 1'b0);
    run_command(OP_WRITE, 8'hFF, 1'b1);
    run_command(OP_READ, 8'hA5, 1'b0);
    run_command(OP_ACK, 8'h00, 1'b1);
    run_command(OP_ACK, 8'hFF, 1'b0);
    run_command(OP_WAIT, 8'h00, 1'b1);
    run_command(OP_WAIT, 8'h00, 1'b0);
    run_command(OP_START, 8'h00, 1'b0);
    run_command(OP_STOP, 8'h00, 1'b0);
    wait_drained();
  endtask

  // The receiver holds off a long stretch while words keep coming.
  task automatic test_output_hold();
    gaps_on = 1'b0;
    hold_seq_req++;
    run_command(OP_START, 8'h00, 1'b0);
    run_command(OP_WRITE, 8'h3C, 1'b0);
    run_command(OP_WAIT, 8'h00, 1'b1);
    wait_drained();
  endtask

  // Random transfers: start, address, ack wait, data with acks, then a stop unless NACKed or skipped, mixed with noise.
  task automatic test_random_transactions();
    int unsigned roll;
    int unsigned n;
    logic [7:0]  addr;
    while (live_words < LiveWords) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        gaps_on = 1'($urandom_range(1));
        stalls_on = 1'($urandom_range(1));
      end
      if (roll >= 94) wait_drained();
      if (roll < 20) begin
        repeat ($urandom_range(1, 6))
          send_word(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        while (bus.op != OP_IDLE)
          send_word(OP_IDLE, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        addr = 8'($urandom);
        run_command(OP_START, 8'h00, 1'b0);
        run_command(OP_WRITE, addr, 1'b0);
        run_command(OP_WAIT, 8'h00, $urandom_range(9) != 0);
        n = $urandom_range(3);
        for (int unsigned k = 0; k < n && !bus.nack; k++) begin
          if (addr[0]) begin
            run_command(OP_READ, 8'($urandom), 1'b0);
            run_command(OP_ACK, 8'h00, k + 1 < n);
          end else begin
            run_command(OP_WRITE, 8'($urandom), 1'b0);
            run_command(OP_WAIT, 8'h00, $urandom_range(9) != 0);
          end
        end
        if (!bus.nack && $urandom_range(4) != 0) run_command(OP_STOP, 8'h00, 1'b0);
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 4))
            send_word(OP_IDLE, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
    wait_drained();
  endtask

  // Receiver side: random stalls, occasional bursts, and long holds on request.
  always @(posedge clk_i) begin : rx_side
    int unsigned roll;
    if (hold_seq_seen != hold_seq_req) begin
      hold_seq_seen <= hold_seq_req;
      hold_left <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall_i <= 1'b1;
    end else if (stalls_on) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        burst_left <= $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= roll < 25;
      end
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compares one field and logs a mismatch.
  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Each result word is checked against the oldest expectation.
  always @(posedge clk_i) begin : line_check
    line_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_lines.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, got scl %0b sda %0b",
                 $time, scl_level_o, sda_level_o);
        mismatches++;
      end else begin
        want = expected_lines.pop_front();
        lines_checked++;
        check_field("scl_level", want.scl, scl_level_o);
        check_field("sda_level", want.sda, sda_level_o);
        check_field("busy_res", want.busy, busy_res_o);
        check_field("done_res", want.done, done_res_o);
        check_field("rx_byte", want.rx, rx_byte_o);
        check_field("ack_seen", want.ack, ack_seen_o);
        check_field("nack_stopped", want.nack, nack_stopped_o);
      end
    end
  end

  // Ends the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, stuck_cycles);
      $display("status: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    bus.op = OP_IDLE;
    bus.phase = '0;
    bus.bits = '0;
    bus.shreg = '0;
    bus.scl = 1'b1;
    bus.sda = 1'b1;
    bus.ack = 1'b0;
    bus.nack = 1'b0;
    bus.rx = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_ticks();
    test_each_command();
    test_output_hold();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_random_transactions();
    repeat (4) @(posedge clk_i);
    $display("covered %0d words, %0d of them bus phases, %0d results checked,",
             words_sent, live_words, lines_checked);
    $display("with random gaps and stalls, a long output hold and drain pauses");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/i2cmbs_pkg.sv
hdl/i2cmbs_step.sv
hdl/i2c_master_bit_sequencer_core.sv
tb/i2c_master_bit_sequencer_core_test.sv
